>>> sv/tksl_pkg.sv
package tksl_pkg;

  // List geometry.
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned ENTRY_BITS = 16;

  // Field widths of the command and result items.
  localparam int unsigned ActW   = 2;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned IdW    = 16;
  localparam int unsigned SlotW  = 6;

  // Internal index and count widths.
  localparam int unsigned IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);

  // Action codes.
  localparam logic [ActW-1:0] ActClear  = 2'd0;
  localparam logic [ActW-1:0] ActInsert = 2'd1;
  localparam logic [ActW-1:0] ActDump   = 2'd2;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [ScoreW-1:0] score;
    logic [IdW-1:0]    entry_id;
  } cmd_t;

  typedef struct packed {
    logic              valid_res;
    logic [SlotW-1:0]  slot;
    logic [ScoreW-1:0] slot_score;
    logic [IdW-1:0]    slot_entry;
    logic              last;
  } res_t;

endpackage

>>> sv/top_k_sorted_score_list.sv
// Sorted list of the best LIST_DEPTH (score, entry id) pairs, lowest score first.
//
// Command channel: cmd_i is taken at a rising edge where start is high and
// busy is low. The action field selects clear, insert or dump; the unused
// action code is dropped without any result.
// Result channel: each result sits on res_o for exactly one cycle, marked by
// res_valid_o. The receiver cannot stall it, so it must take every strobe.
//
// Sequencing: clear answers straight from the idle state. Insert walks from
// the tail toward the head one slot per cycle through a single
// compare-and-move step; on a full list a drop check comes first, which
// answers a rejected pair itself and passes a taken one on to the walk. A
// dump reports one stored entry per cycle; an empty list answers from the
// idle state with a single empty result. busy drops as the final result reaches
// the port, and a new command may be accepted in that cycle.
//
// Reset clears the fill count, the sequencer and the result strobe only; the
// score and id storage holds garbage until written, and slots at or above
// the count are never reported.
module top_k_sorted_score_list
  import tksl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output res_t res_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCheck = 4'b0010,
    StShift = 4'b0100,
    StDump  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Storage: one slot written and one slot read per cycle.
  logic [ScoreW-1:0]     kept_scores_q  [LIST_DEPTH];
  logic [ENTRY_BITS-1:0] kept_entries_q [LIST_DEPTH];

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  cmd_t            cmd_q;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  logic            accept;
  logic [IdxW-1:0] rd_idx;
  logic [ScoreW-1:0] rd_score;
  logic [ENTRY_BITS-1:0] rd_entry;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [ScoreW-1:0] wr_score;
  logic [ENTRY_BITS-1:0] wr_entry;
  logic            move_down;
  logic            cnt_full;

  assign accept   = start && !busy;
  assign busy     = (state_q != StIdle);
  assign cnt_full = (cnt_q == CntW'(LIST_DEPTH));

  // The shift step looks at the slot above the write position; the full
  // check looks at the worst slot; a dump reads the slot being reported.
  always_comb begin
    case (state_q)
      StShift: rd_idx = idx_q - IdxW'(1);
      StCheck: rd_idx = IdxW'(LIST_DEPTH - 1);
      default: rd_idx = idx_q;
    endcase
  end

  assign rd_score  = kept_scores_q[rd_idx];
  assign rd_entry  = kept_entries_q[rd_idx];
  assign move_down = (idx_q != '0) && (cmd_q.score < rd_score);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    wr_en       = 1'b0;
    wr_idx      = idx_q;
    wr_score    = rd_score;
    wr_entry    = rd_entry;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (cmd_i.action)
            ActClear: begin
              cnt_d       = '0;
              res_valid_d = 1'b1;
            end
            ActInsert: begin
              if (cnt_full) begin
                state_d = StCheck;
              end else begin
                idx_d   = cnt_q[IdxW-1:0];
                state_d = StShift;
              end
            end
            ActDump: begin
              if (cnt_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = StDump;
              end
            end
            default: ;
          endcase
        end
      end

      StCheck: begin
        // A full list takes the pair only if it beats the worst entry.
        if (cmd_q.score < rd_score) begin
          idx_d   = IdxW'(LIST_DEPTH - 1);
          state_d = StShift;
        end else begin
          res_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      StShift: begin
        wr_en = 1'b1;
        if (move_down) begin
          // Slide the worse neighbor down one place and keep walking up.
          idx_d = idx_q - IdxW'(1);
        end else begin
          wr_score          = cmd_q.score;
          wr_entry          = ENTRY_BITS'(cmd_q.entry_id);
          if (!cnt_full) begin
            cnt_d = cnt_q + CntW'(1);
          end
          res_valid_d       = 1'b1;
          res_d.valid_res   = 1'b1;
          res_d.slot        = SlotW'(idx_q);
          res_d.slot_score  = cmd_q.score;
          res_d.slot_entry  = IdW'(wr_entry);
          state_d           = StIdle;
        end
      end

      StDump: begin
        res_valid_d      = 1'b1;
        res_d.valid_res  = 1'b1;
        res_d.slot       = SlotW'(idx_q);
        res_d.slot_score = rd_score;
        res_d.slot_entry = IdW'(rd_entry);
        res_d.last       = (CntW'(idx_q) + CntW'(1) == cnt_q);
        idx_d            = idx_q + IdxW'(1);
        if (res_d.last) begin
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (wr_en) begin
      kept_scores_q[wr_idx]  <= wr_score;
      kept_entries_q[wr_idx] <= wr_entry;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The fill count never passes the list depth.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(LIST_DEPTH))
    else $error("fill count exceeds list depth");

  // A result that is not the last one is always followed by another result.
  a_dump_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o)
    else $error("item stream broken before its last result");

  // A clear answers in the next cycle with an empty result and an empty list.
  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i.action == ActClear |=>
      res_valid_o && res_o.last && !res_o.valid_res && cnt_q == '0)
    else $error("clear did not answer as expected");

  // Results only appear when the sequencer has work to finish.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !accept |=> !res_valid_o)
    else $error("result without a command");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tksl_pkg::*;

  // Run limits. The slowest correct item is a full-list insert or a full dump,
  // and the sender idles before an item with a chance of at most 80 percent,
  // so the cycle limit below is many times what a run needs.
  localparam int unsigned NumItems   = 430;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 2 * LIST_DEPTH + 8;
  localparam int unsigned MaxPrinted = 40;
  localparam logic [ScoreW-1:0] ScoreMax = 32'hFFFE_0001;

  // The one action code that the block ignores.
  localparam logic [ActW-1:0] ActUnused = 2'd3;

  // One pending command item, together with the chance (in percent) that the
  // sender idles at an edge instead of presenting it.
  typedef struct {
    cmd_t        cmd;
    int unsigned gap_pct;
  } pending_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  cmd_t cmd_i  = '0;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  top_k_sorted_score_list uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Command items waiting to be sent, and the results that the accepted
  // items must still produce, oldest first.
  pending_t pending[$];
  res_t     expected_results[$];

  // Our own copy of the sorted list, updated as each item is accepted.
  logic [ScoreW-1:0] kept_score [LIST_DEPTH];
  logic [IdW-1:0]    kept_id    [LIST_DEPTH];
  int unsigned       kept_len;

  // Bookkeeping for the mismatch count and the closing summary.
  int unsigned n_errors;
  int unsigned n_accepted;
  int unsigned n_clears;
  int unsigned n_taken;
  int unsigned n_rejected;
  int unsigned n_evicted;
  int unsigned n_dumps;
  int unsigned n_ignored;
  int unsigned n_checked;
  int unsigned n_queued;
  int unsigned gap_now;
  int unsigned cycle_cnt;
  res_t        got_res;
  res_t        want_res;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= MaxPrinted) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Works out what one accepted item must produce, and updates the list.
  // A rejected insert, a clear and a dump of an empty list all answer with a
  // single all-zero result that is marked last.
  function automatic void predict_list_update(cmd_t c);
    res_t        r;
    int unsigned pos;
    int unsigned n;
    int unsigned i;

    r      = '0;
    r.last = 1'b1;
    n      = kept_len;
    n_accepted++;
    case (c.action)
      ActClear: begin
        kept_len = 0;
        n_clears++;
        expected_results.push_back(r);
      end
      ActInsert: begin
        // The new pair goes after every entry with an equal or lower score,
        // so an earlier arrival keeps its place on a tie.
        pos = n;
        while (pos > 0 && c.score < kept_score[pos-1]) begin
          pos--;
        end
        if (pos >= LIST_DEPTH) begin
          n_rejected++;
        end else begin
          if (n < LIST_DEPTH) begin
            n++;
          end else begin
            n_evicted++;
          end
          for (i = n - 1; i > pos; i--) begin
            kept_score[i] = kept_score[i-1];
            kept_id[i]    = kept_id[i-1];
          end
          kept_score[pos] = c.score;
          kept_id[pos]    = c.entry_id;
          kept_len        = n;
          r.valid_res     = 1'b1;
          r.slot          = SlotW'(pos);
          r.slot_score    = c.score;
          r.slot_entry    = c.entry_id;
          n_taken++;
        end
        expected_results.push_back(r);
      end
      ActDump: begin
        n_dumps++;
        if (n == 0) begin
          expected_results.push_back(r);
        end else begin
          for (i = 0; i < n; i++) begin
            r.valid_res  = 1'b1;
            r.slot       = SlotW'(i);
            r.slot_score = kept_score[i];
            r.slot_entry = kept_id[i];
            r.last       = (i + 1 == n);
            expected_results.push_back(r);
          end
        end
      end
      default: begin
        // The unused action code leaves the list alone and answers nothing.
        n_accepted--;
        n_ignored++;
      end
    endcase
  endfunction

  // Command driver. An item is taken at an edge where start is high and busy
  // is low. While an item waits on a busy block it is held as it is; at every
  // other edge the driver either presents the next item or idles.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_list_update(cmd_i);
        void'(pending.pop_front());
      end
      if (!(start && busy)) begin
        if (pending.size() != 0 && $urandom_range(99) >= pending[0].gap_pct) begin
          start <= 1'b1;
          cmd_i <= pending[0].cmd;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor. The block cannot be stalled, so every strobe is a result
  // that is checked at once against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o !== 1'b0) begin
      got_res = res_o;
      if (res_valid_o !== 1'b1) begin
        report_mismatch("result strobe is unknown");
      end else if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%0h", got_res));
      end else begin
        want_res = expected_results.pop_front();
        n_checked++;
        check_field("valid_res", 32'(got_res.valid_res), 32'(want_res.valid_res));
        check_field("slot", 32'(got_res.slot), 32'(want_res.slot));
        check_field("slot_score", got_res.slot_score, want_res.slot_score);
        check_field("slot_entry", 32'(got_res.slot_entry), 32'(want_res.slot_entry));
        check_field("last", 32'(got_res.last), 32'(want_res.last));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_cnt, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Queues one command item at the current sender idle rate. Items with the
  // unused action code do not count toward the item budget.
  task automatic queue_cmd(logic [ActW-1:0] act, logic [ScoreW-1:0] sc,
                           logic [IdW-1:0] id);
    pending_t p;

    p.cmd.action   = act;
    p.cmd.score    = sc;
    p.cmd.entry_id = id;
    p.gap_pct      = gap_now;
    pending.push_back(p);
    if (act != ActUnused) begin
      n_queued++;
    end
  endtask

  // Score patterns for one insert run. Narrow ranges give many ties, mostly
  // falling scores make most inserts walk the whole list, and the wide modes reach
  // the top bits and the ends of the range.
  function automatic logic [ScoreW-1:0] pick_score(int unsigned mode, int unsigned step);
    case (mode)
      0: return $urandom_range(7);
      1: return $urandom_range(ScoreMax, 0);
      2: begin
        case ($urandom_range(3))
          0: return '0;
          1: return ScoreMax;
          default: return $urandom_range(ScoreMax, 0);
        endcase
      end
      3: return 32'd5000 - step * $urandom_range(1, 3);
      default: return 32'd200 + $urandom_range(40);
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    int unsigned phase;
    int unsigned mode;
    int unsigned run_len;
    int unsigned j;
    int unsigned idle_pct[4];

    // Sender idle rates of the four random phases; the first and third run
    // without sender gaps.
    idle_pct = '{0, 80, 0, 34};
    gap_now  = 0;

    // Directed part: empty list, the ignored action code, field extremes,
    // ties, filling the list, a rejected insert, an insert that evicts the
    // worst entry, a full dump, a clear followed by an empty dump, and one more insert.
    queue_cmd(ActDump, '0, '0);
    queue_cmd(ActUnused, ScoreMax, 16'hFFFF);
    queue_cmd(ActClear, 32'h1234_5678, 16'h5A5A);
    queue_cmd(ActInsert, 32'd100, 16'h0000);
    queue_cmd(ActInsert, 32'd100, 16'hFFFF);
    queue_cmd(ActInsert, 32'd0, 16'h1234);
    queue_cmd(ActInsert, ScoreMax, 16'hA5A5);
    for (j = 0; j < LIST_DEPTH - 4; j++) begin
      queue_cmd(ActInsert, 32'd50, IdW'(j + 1));
    end
    queue_cmd(ActInsert, ScoreMax, 16'h7777);
    queue_cmd(ActInsert, 32'd1, 16'h8001);
    queue_cmd(ActDump, '0, '0);
    queue_cmd(ActClear, '0, '0);
    queue_cmd(ActDump, '0, '0);
    queue_cmd(ActInsert, 32'd0, 16'hFFFF);

    // Random part. Most of it is well-formed runs: a clear, a burst of
    // inserts with the odd dump mixed in, and a closing dump. The rest is
    // loose single items of any action, which also break up runs.
    while (n_queued < NumItems) begin
      phase   = (n_queued * 4) / NumItems;
      gap_now = idle_pct[phase];
      if ($urandom_range(9) == 0) begin
        queue_cmd(ActW'($urandom_range(3)), pick_score($urandom_range(4), 0),
                  IdW'($urandom_range(16'hFFFF)));
      end else begin
        mode    = $urandom_range(4);
        run_len = $urandom_range(1, LIST_DEPTH + 8);
        queue_cmd(ActClear, $urandom, IdW'($urandom_range(16'hFFFF)));
        for (j = 0; j < run_len; j++) begin
          queue_cmd(ActInsert, pick_score(mode, j), IdW'($urandom_range(16'hFFFF)));
          if ($urandom_range(7) == 0) begin
            queue_cmd(ActDump, $urandom, IdW'($urandom_range(16'hFFFF)));
          end
        end
        queue_cmd(ActDump, $urandom, IdW'($urandom_range(16'hFFFF)));
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait until every item has gone in and every result has come out, then
    // give the block time to show any stray result.
    do begin
      @(negedge clk_i);
    end while (pending.size() != 0 || start || expected_results.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    $display("Run covered %0d commands: %0d clears, %0d dumps, %0d ignored codes.",
             n_accepted + n_ignored, n_clears, n_dumps, n_ignored);
    $display("Inserts: %0d placed, %0d evicting the worst, %0d rejected; %0d results checked.",
             n_taken, n_evicted, n_rejected, n_checked);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
